// ----- rtl/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// Star pattern matcher package
// Shared widths, codes, command and status types, and a small helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  // Store sizes.
  localparam int MaxField   = 64;
  localparam int MaxPattern = 16;
  localparam int FieldAw    = $clog2(MaxField);
  localparam int PatAw      = $clog2(MaxPattern);
  localparam int FieldCw    = $clog2(MaxField + 1);
  localparam int PatCw      = $clog2(MaxPattern + 1);

  // Arithmetic widths.
  localparam int CoordW  = 20;
  localparam int StarW   = 2 * CoordW;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int NumW    = ProdW + 1;
  localparam int DenW    = ProdW;
  localparam int FracW   = 20;
  localparam int DvdW    = DenW + FracW;
  localparam int DivCntW = $clog2(DvdW);
  localparam int QW      = 32;
  localparam int ErrW    = QW + 1;
  localparam int AbsW    = 22;
  localparam int SqW     = 2 * AbsW;
  localparam int SumW    = SqW + 1;
  localparam int ThrW    = 40;

  localparam logic [ThrW-1:0] ThrReset  = ThrW'(10995116);
  localparam logic [ErrW-1:0] ErrLimit  = ErrW'(2097152);
  localparam logic [DvdW-1:0] QPosLimit = DvdW'(64'h7FFF_FFFF);
  localparam logic [DvdW-1:0] QNegLimit = DvdW'(64'h8000_0000);

  // Pattern stars before this index are the reference pair.
  localparam logic [PatCw-1:0] PatBase    = PatCw'(2);
  localparam logic [PatCw-1:0] MinPattern = PatCw'(3);

  // Operation codes of an input item.
  localparam logic [1:0] OpField   = 2'd0;
  localparam logic [1:0] OpPattern = 2'd1;
  localparam logic [1:0] OpRun     = 2'd2;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFew      = 2'd1,
    StDegen    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DivPattern = 2'd0,
    DivField   = 2'd1,
    DivScale   = 2'd2
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               ld_fld;
    logic               ld_pat;
    logic               fld_rd;
    logic [FieldAw-1:0] fld_addr;
    logic               pat_rd;
    logic [PatAw-1:0]   pat_addr;
    logic               pn_rd;
    logic               pn_wr;
    logic [PatAw-1:0]   pn_addr;
    logic               ld_p0;
    logic               ld_cd;
    logic               ld_j;
    logic               ld_fd;
    logic               div_start;
    div_sel_e           div_sel;
    logic               chk1;
    logic               chk2;
    logic               chk3;
    logic               res_ld;
    logic               res_match;
    status_e            res_status;
  } spm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FieldCw-1:0] fld_cnt;
    logic [PatCw-1:0]   pat_cnt;
    logic               ovf;
    logic               cd_zero;
    logic               fd_zero;
    logic               div_done;
    logic               close;
    logic               out_free;
  } spm_sts_t;

  // Signed difference of two unsigned coordinates.
  function automatic logic signed [DiffW-1:0] cdiff(input logic [CoordW-1:0] a,
                                                    input logic [CoordW-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spm_cdiv.sv -----
// ----------------------------------------------------------------------------
// Complex divider
// Computes (n_re + i n_im) / (d_re + i d_im) with one shared multiplier and a
// bit-serial restoring divider, rounded and saturated to signed Q11.20.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_cdiv (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [spm_pkg::DiffW-1:0]  n_re_i,
  input  wire logic signed [spm_pkg::DiffW-1:0]  n_im_i,
  input  wire logic signed [spm_pkg::DiffW-1:0]  d_re_i,
  input  wire logic signed [spm_pkg::DiffW-1:0]  d_im_i,
  output logic                                   done_o,
  output logic signed [spm_pkg::QW-1:0]          q_re_o,
  output logic signed [spm_pkg::QW-1:0]          q_im_o
);
  import spm_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_MUL,
    C_DIV
  } cstate_e;

  localparam logic [2:0] LastMul = 3'd6;

  cstate_e              state_q;
  logic [2:0]           step_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 phase_q;
  logic                 done_q;

  logic signed [DiffW-1:0] nr_q, ni_q, dr_q, di_q;
  logic signed [ProdW-1:0] prod_q;
  logic [DenW-1:0]         den_q;
  logic signed [NumW-1:0]  numr_q, numi_q;
  logic [DenW-1:0]         rem_q;
  logic [DvdW-1:0]         dvd_q;
  logic signed [QW-1:0]    q_re_q, q_im_q;

  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [DenW:0]           rem_sh, rem_n;
  logic                    ge;
  logic [DvdW-1:0]         quo;

  // Rounded dividend: |num| * 2^20 + den / 2.
  function automatic logic [DvdW-1:0] dvd_init(input logic signed [NumW-1:0] num,
                                               input logic [DenW-1:0] den);
    logic [NumW-1:0] a;
    a = num[NumW-1] ? NumW'(-num) : NumW'(num);
    return {a[DenW-1:0], FracW'(0)} + DvdW'(den[DenW-1:1]);
  endfunction

  // Apply the sign and saturate to the signed 32-bit range.
  function automatic logic signed [QW-1:0] sat_q(input logic neg,
                                                 input logic [DvdW-1:0] q);
    logic signed [QW-1:0] r;
    if (neg) begin
      r = (q > QNegLimit) ? $signed(QNegLimit[QW-1:0]) : $signed(QW'(0) - q[QW-1:0]);
    end else begin
      r = (q > QPosLimit) ? $signed(QPosLimit[QW-1:0]) : $signed(q[QW-1:0]);
    end
    return r;
  endfunction

  // Multiplier operands for each product step.
  always_comb begin
    case (step_q)
      3'd0: begin mul_a = dr_q; mul_b = dr_q; end
      3'd1: begin mul_a = di_q; mul_b = di_q; end
      3'd2: begin mul_a = nr_q; mul_b = dr_q; end
      3'd3: begin mul_a = ni_q; mul_b = di_q; end
      3'd4: begin mul_a = ni_q; mul_b = dr_q; end
      3'd5: begin mul_a = nr_q; mul_b = di_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_q, dvd_q[DvdW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
    quo    = {dvd_q[DvdW-2:0], ge};
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_MUL;
            step_q  <= '0;
          end
        end
        C_MUL: begin
          step_q <= step_q + 3'd1;
          if (step_q == LastMul) begin
            state_q <= C_DIV;
            cnt_q   <= '0;
            phase_q <= 1'b0;
          end
        end
        C_DIV: begin
          cnt_q <= cnt_q + DivCntW'(1);
          if (cnt_q == DivCntW'(DvdW - 1)) begin
            cnt_q <= '0;
            if (phase_q) begin
              state_q <= C_IDLE;
              done_q  <= 1'b1;
            end else begin
              phase_q <= 1'b1;
            end
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // Operands, products and the divider registers.
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      nr_q <= n_re_i;
      ni_q <= n_im_i;
      dr_q <= d_re_i;
      di_q <= d_im_i;
    end
    if (state_q == C_MUL) begin
      prod_q <= mul_p;
      case (step_q)
        3'd1: den_q  <= DenW'(prod_q);
        3'd2: den_q  <= den_q + DenW'(prod_q);
        3'd3: numr_q <= NumW'(prod_q);
        3'd4: numr_q <= numr_q + NumW'(prod_q);
        3'd5: numi_q <= NumW'(prod_q);
        3'd6: begin
          numi_q <= numi_q - NumW'(prod_q);
          rem_q  <= '0;
          dvd_q  <= dvd_init(numr_q, den_q);
        end
        default: ;
      endcase
    end
    if (state_q == C_DIV) begin
      rem_q <= rem_n[DenW-1:0];
      dvd_q <= quo;
      if (cnt_q == DivCntW'(DvdW - 1)) begin
        if (!phase_q) begin
          q_re_q <= sat_q(numr_q[NumW-1], quo);
          rem_q  <= '0;
          dvd_q  <= dvd_init(numi_q, den_q);
        end else begin
          q_im_q <= sat_q(numi_q[NumW-1], quo);
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_re_o = q_re_q;
  assign q_im_o = q_im_q;

endmodule

`default_nettype wire

// ----- rtl/spm_dpath.sv -----
// ----------------------------------------------------------------------------
// Star pattern matcher datapath
// Star stores, normalized pattern store, operand registers, complex divider,
// closeness check, threshold register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire spm_pkg::spm_cmd_t              cmd_i,
  output spm_pkg::spm_sts_t                   sts_o,
  input  wire logic                           restart_i,
  input  wire logic [spm_pkg::CoordW-1:0]     coord_x_i,
  input  wire logic [spm_pkg::CoordW-1:0]     coord_y_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [spm_pkg::ThrW-1:0]       cfg_wdata_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                matched_o,
  output logic signed [spm_pkg::QW-1:0]       scale_re_o,
  output logic signed [spm_pkg::QW-1:0]       scale_im_o,
  output logic [spm_pkg::CoordW-1:0]          position_x_o,
  output logic [spm_pkg::CoordW-1:0]          position_y_o,
  output logic [1:0]                          status_o
);
  import spm_pkg::*;

  // Stores.
  logic [StarW-1:0]  field_mem [MaxField];
  logic [StarW-1:0]  pat_mem   [MaxPattern];
  logic [2*QW-1:0]   pn_mem    [MaxPattern];
  logic [StarW-1:0]  fld_rdata_q, pat_rdata_q;
  logic [2*QW-1:0]   pn_rdata_q;

  logic [ThrW-1:0]    thr_q;
  logic [FieldCw-1:0] fld_cnt_q;
  logic [PatCw-1:0]   pat_cnt_q;
  logic               ovf_q;

  logic [StarW-1:0]   star;
  logic               fld_we, pat_we;
  logic [FieldAw-1:0] fld_waddr;
  logic [PatAw-1:0]   pat_waddr;

  logic [CoordW-1:0]       p0x_q, p0y_q, jx_q, jy_q;
  logic signed [DiffW-1:0] cdr_q, cdi_q, fdr_q, fdi_q;

  logic signed [DiffW-1:0] n_re, n_im, d_re, d_im;
  logic                    div_done;
  logic signed [QW-1:0]    q_re, q_im;

  logic signed [ErrW-1:0] er, ei;
  logic [ErrW-1:0]        ear, eai;
  logic [AbsW-1:0]        ea_q, eb_q;
  logic                   big_q;
  logic [SqW-1:0]         sqa_q, sqb_q;
  logic [SumW-1:0]        sq_sum;

  logic                   out_valid_q, matched_q;
  logic signed [QW-1:0]   scale_re_q, scale_im_q;
  logic [CoordW-1:0]      pos_x_q, pos_y_q;
  status_e                status_q;
  logic                   out_free;

  // Load decode: a restart empties the list, a full list drops the star.
  assign star      = {coord_y_i, coord_x_i};
  assign fld_we    = cmd_i.ld_fld && (restart_i || fld_cnt_q < FieldCw'(MaxField));
  assign pat_we    = cmd_i.ld_pat && (restart_i || pat_cnt_q < PatCw'(MaxPattern));
  assign fld_waddr = restart_i ? '0 : fld_cnt_q[FieldAw-1:0];
  assign pat_waddr = restart_i ? '0 : pat_cnt_q[PatAw-1:0];

  // Counts, overflow flag and threshold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_cnt_q <= '0;
      pat_cnt_q <= '0;
      ovf_q     <= 1'b0;
      thr_q     <= ThrReset;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.ld_fld) begin
        if (restart_i) begin
          fld_cnt_q <= FieldCw'(1);
          ovf_q     <= 1'b0;
        end else if (fld_we) begin
          fld_cnt_q <= fld_cnt_q + FieldCw'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.ld_pat) begin
        if (restart_i) begin
          pat_cnt_q <= PatCw'(1);
          ovf_q     <= 1'b0;
        end else if (pat_we) begin
          pat_cnt_q <= pat_cnt_q + PatCw'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // Field store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (fld_we) begin
      field_mem[fld_waddr] <= star;
    end
    if (cmd_i.fld_rd) begin
      fld_rdata_q <= field_mem[cmd_i.fld_addr];
    end
  end

  // Pattern store.
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= star;
    end
    if (cmd_i.pat_rd) begin
      pat_rdata_q <= pat_mem[cmd_i.pat_addr];
    end
  end

  // Normalized pattern store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pn_wr) begin
      pn_mem[cmd_i.pn_addr] <= {q_im, q_re};
    end
    if (cmd_i.pn_rd) begin
      pn_rdata_q <= pn_mem[cmd_i.pn_addr];
    end
  end

  // Reference points and divisors.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_p0) begin
      p0x_q <= pat_rdata_q[CoordW-1:0];
      p0y_q <= pat_rdata_q[StarW-1:CoordW];
    end
    if (cmd_i.ld_cd) begin
      cdr_q <= cdiff(p0x_q, pat_rdata_q[CoordW-1:0]);
      cdi_q <= cdiff(p0y_q, pat_rdata_q[StarW-1:CoordW]);
    end
    if (cmd_i.ld_j) begin
      jx_q <= fld_rdata_q[CoordW-1:0];
      jy_q <= fld_rdata_q[StarW-1:CoordW];
    end
    if (cmd_i.ld_fd) begin
      fdr_q <= cdiff(jx_q, fld_rdata_q[CoordW-1:0]);
      fdi_q <= cdiff(jy_q, fld_rdata_q[StarW-1:CoordW]);
    end
  end

  // Divider operand selection.
  always_comb begin
    case (cmd_i.div_sel)
      DivPattern: begin
        n_re = cdiff(pat_rdata_q[CoordW-1:0], p0x_q);
        n_im = cdiff(pat_rdata_q[StarW-1:CoordW], p0y_q);
        d_re = cdr_q;
        d_im = cdi_q;
      end
      DivField: begin
        n_re = cdiff(fld_rdata_q[CoordW-1:0], jx_q);
        n_im = cdiff(fld_rdata_q[StarW-1:CoordW], jy_q);
        d_re = fdr_q;
        d_im = fdi_q;
      end
      default: begin
        n_re = cdr_q;
        n_im = cdi_q;
        d_re = fdr_q;
        d_im = fdi_q;
      end
    endcase
  end

  spm_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .n_re_i  (n_re),
    .n_im_i  (n_im),
    .d_re_i  (d_re),
    .d_im_i  (d_im),
    .done_o  (div_done),
    .q_re_o  (q_re),
    .q_im_o  (q_im)
  );

  // Closeness check: error magnitudes, then one square per cycle.
  assign er  = ErrW'(q_re) - ErrW'($signed(pn_rdata_q[QW-1:0]));
  assign ei  = ErrW'(q_im) - ErrW'($signed(pn_rdata_q[2*QW-1:QW]));
  assign ear = er[ErrW-1] ? ErrW'(-er) : ErrW'(er);
  assign eai = ei[ErrW-1] ? ErrW'(-ei) : ErrW'(ei);

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk1) begin
      big_q <= (ear > ErrLimit) || (eai > ErrLimit);
      ea_q  <= ear[AbsW-1:0];
      eb_q  <= eai[AbsW-1:0];
    end
    if (cmd_i.chk2) begin
      sqa_q <= ea_q * ea_q;
    end
    if (cmd_i.chk3) begin
      sqb_q <= eb_q * eb_q;
    end
  end

  assign sq_sum = SumW'(sqa_q) + SumW'(sqb_q);

  // Result register.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      matched_q  <= cmd_i.res_match;
      scale_re_q <= cmd_i.res_match ? q_re : '0;
      scale_im_q <= cmd_i.res_match ? q_im : '0;
      pos_x_q    <= cmd_i.res_match ? jx_q : '0;
      pos_y_q    <= cmd_i.res_match ? jy_q : '0;
      status_q   <= cmd_i.res_status;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.fld_cnt  = fld_cnt_q;
    sts_o.pat_cnt  = pat_cnt_q;
    sts_o.ovf      = ovf_q;
    sts_o.cd_zero  = (cdr_q == '0) && (cdi_q == '0);
    sts_o.fd_zero  = (fdr_q == '0) && (fdi_q == '0);
    sts_o.div_done = div_done;
    sts_o.close    = !big_q && (sq_sum < SumW'(thr_q));
    sts_o.out_free = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign matched_o    = matched_q;
  assign scale_re_o   = scale_re_q;
  assign scale_im_o   = scale_im_q;
  assign position_x_o = pos_x_q;
  assign position_y_o = pos_y_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ----- rtl/spm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Star pattern matcher controller
// Accepts items, walks the pattern normalization and the field pair search,
// and sequences the datapath through reads, divisions and checks.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire spm_pkg::spm_sts_t    sts_i,
  output spm_pkg::spm_cmd_t         cmd_o
);
  import spm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_P0,
    S_P1,
    S_CD,
    S_PN_RD,
    S_PN_DIV,
    S_J_TEST,
    S_J_RD,
    S_K_TEST,
    S_K_RD,
    S_K_CHK,
    S_L_TEST,
    S_L_RD,
    S_L_DIV,
    S_CHK2,
    S_CHK3,
    S_CHK4,
    S_SC_DIV,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [PatCw-1:0]   i_q, i_d, i_nx;
  logic [FieldCw-1:0] j_q, j_d, k_q, k_d, l_q, l_d;
  logic               res_match_q, res_match_d;
  status_e            res_status_q, res_status_d;

  assign i_nx = i_q + PatCw'(1);

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    l_d          = l_q;
    res_match_d  = res_match_q;
    res_status_d = res_status_q;
    cmd_o        = '0;
    cmd_o.res_match  = res_match_q;
    cmd_o.res_status = res_status_q;
    cmd_o.div_sel    = DivField;
    cmd_o.fld_addr   = j_q[FieldAw-1:0];
    cmd_o.pat_addr   = i_q[PatAw-1:0];
    cmd_o.pn_addr    = i_q[PatAw-1:0];
    in_ready_o       = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_i)
            OpField:   cmd_o.ld_fld = 1'b1;
            OpPattern: cmd_o.ld_pat = 1'b1;
            OpRun: begin
              res_match_d = 1'b0;
              if (sts_i.ovf) begin
                res_status_d = StOverflow;
                state_d      = S_DONE;
              end else if (sts_i.pat_cnt < MinPattern) begin
                res_status_d = StFew;
                state_d      = S_DONE;
              end else begin
                cmd_o.pat_rd   = 1'b1;
                cmd_o.pat_addr = '0;
                state_d        = S_P0;
              end
            end
            default: ;
          endcase
        end
      end
      // Reference pair of the pattern.
      S_P0: begin
        cmd_o.ld_p0    = 1'b1;
        cmd_o.pat_rd   = 1'b1;
        cmd_o.pat_addr = PatAw'(1);
        state_d        = S_P1;
      end
      S_P1: begin
        cmd_o.ld_cd = 1'b1;
        state_d     = S_CD;
      end
      S_CD: begin
        if (sts_i.cd_zero) begin
          res_status_d = StDegen;
          state_d      = S_DONE;
        end else begin
          i_d            = PatBase;
          cmd_o.pat_rd   = 1'b1;
          cmd_o.pat_addr = PatBase[PatAw-1:0];
          state_d        = S_PN_RD;
        end
      end
      // Normalize the remaining pattern stars.
      S_PN_RD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivPattern;
        state_d         = S_PN_DIV;
      end
      S_PN_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.pn_wr = 1'b1;
          if (i_nx == sts_i.pat_cnt) begin
            j_d     = '0;
            state_d = S_J_TEST;
          end else begin
            i_d            = i_nx;
            cmd_o.pat_rd   = 1'b1;
            cmd_o.pat_addr = i_nx[PatAw-1:0];
            state_d        = S_PN_RD;
          end
        end
      end
      // Outer loop over the first star of the field pair.
      S_J_TEST: begin
        if (j_q == sts_i.fld_cnt) begin
          res_status_d = StOk;
          state_d      = S_DONE;
        end else begin
          cmd_o.fld_rd   = 1'b1;
          cmd_o.fld_addr = j_q[FieldAw-1:0];
          state_d        = S_J_RD;
        end
      end
      S_J_RD: begin
        cmd_o.ld_j = 1'b1;
        k_d        = '0;
        state_d    = S_K_TEST;
      end
      // Inner loop over the second star of the pair.
      S_K_TEST: begin
        if (k_q == sts_i.fld_cnt) begin
          j_d     = j_q + FieldCw'(1);
          state_d = S_J_TEST;
        end else if (k_q == j_q) begin
          k_d = k_q + FieldCw'(1);
        end else begin
          cmd_o.fld_rd   = 1'b1;
          cmd_o.fld_addr = k_q[FieldAw-1:0];
          state_d        = S_K_RD;
        end
      end
      S_K_RD: begin
        cmd_o.ld_fd = 1'b1;
        state_d     = S_K_CHK;
      end
      S_K_CHK: begin
        if (sts_i.fd_zero) begin
          k_d     = k_q + FieldCw'(1);
          state_d = S_K_TEST;
        end else begin
          i_d     = PatBase;
          l_d     = '0;
          state_d = S_L_TEST;
        end
      end
      // Search the field for a star close to pattern star i.
      S_L_TEST: begin
        if (l_q == sts_i.fld_cnt) begin
          k_d     = k_q + FieldCw'(1);
          state_d = S_K_TEST;
        end else if (l_q == j_q || l_q == k_q) begin
          l_d = l_q + FieldCw'(1);
        end else begin
          cmd_o.fld_rd   = 1'b1;
          cmd_o.fld_addr = l_q[FieldAw-1:0];
          cmd_o.pn_rd    = 1'b1;
          state_d        = S_L_RD;
        end
      end
      S_L_RD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivField;
        state_d         = S_L_DIV;
      end
      S_L_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.chk1 = 1'b1;
          state_d    = S_CHK2;
        end
      end
      S_CHK2: begin
        cmd_o.chk2 = 1'b1;
        state_d    = S_CHK3;
      end
      S_CHK3: begin
        cmd_o.chk3 = 1'b1;
        state_d    = S_CHK4;
      end
      S_CHK4: begin
        if (sts_i.close) begin
          if (i_nx == sts_i.pat_cnt) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DivScale;
            state_d         = S_SC_DIV;
          end else begin
            i_d     = i_nx;
            l_d     = '0;
            state_d = S_L_TEST;
          end
        end else begin
          l_d     = l_q + FieldCw'(1);
          state_d = S_L_TEST;
        end
      end
      // Scale and rotation of the matching pair.
      S_SC_DIV: begin
        cmd_o.div_sel = DivScale;
        if (sts_i.div_done) begin
          res_match_d  = 1'b1;
          res_status_d = StOk;
          state_d      = S_DONE;
        end
      end
      // Hand the result over once the output register is free.
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, loop counters and the pending result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      l_q          <= '0;
      res_match_q  <= 1'b0;
      res_status_q <= StOk;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      l_q          <= l_d;
      res_match_q  <= res_match_d;
      res_status_q <= res_status_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/star_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// Star pattern matcher
// Similarity-invariant search of a stored star pattern in a stored star field.
// ----------------------------------------------------------------------------
// Load items (field star or pattern star) produce no result. A run item
// produces one result. Every complex quotient keeps the shared divider busy
// for 7 multiply steps, then 62 quotient bits for each of the two components;
// pattern normalization costs one quotient per pattern star past the second,
// and the pair search costs one quotient for each (pair, field star)
// candidate examined. The input is not accepted while a run is in progress; a
// result waits in the output register.
`default_nettype none

module star_pattern_matcher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic                        restart_i,
  input  wire logic [spm_pkg::CoordW-1:0]  coord_x_i,
  input  wire logic [spm_pkg::CoordW-1:0]  coord_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             matched_o,
  output logic signed [spm_pkg::QW-1:0]    scale_re_o,
  output logic signed [spm_pkg::QW-1:0]    scale_im_o,
  output logic [spm_pkg::CoordW-1:0]       position_x_o,
  output logic [spm_pkg::CoordW-1:0]       position_y_o,
  output logic [1:0]                       status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [spm_pkg::ThrW-1:0]    cfg_wdata_i
);
  import spm_pkg::*;

  spm_cmd_t cmd;
  spm_sts_t sts;

  spm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spm_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .restart_i    (restart_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .matched_o    (matched_o),
    .scale_re_o   (scale_re_o),
    .scale_im_o   (scale_im_o),
    .position_x_o (position_x_o),
    .position_y_o (position_y_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

// ----- bench/star_pattern_matcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Star pattern matcher testbench
// Loads field and pattern stars, runs the search under several thresholds and
// handshake idling phases, and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module star_pattern_matcher_tb;
  import spm_pkg::*;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int WatchLimit = 400000;
  localparam int HoldCycles = 40000;
  localparam int PhaseItems = 400;

  typedef struct packed {
    logic               matched;
    logic signed [31:0] scale_re;
    logic signed [31:0] scale_im;
    logic [19:0]        position_x;
    logic [19:0]        position_y;
    status_e            status;
  } match_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        restart;
    logic [19:0] x;
    logic [19:0] y;
    logic        typed;
    status_e     exp_status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = OpField;
  logic restart_i = 1'b0;
  logic [19:0] coord_x_i = '0;
  logic [19:0] coord_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic matched_o;
  logic signed [31:0] scale_re_o, scale_im_o;
  logic [19:0] position_x_o, position_y_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [39:0] cfg_wdata_i = '0;

  star_pattern_matcher dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [19:0] fld_x [MaxField];
  logic [19:0] fld_y [MaxField];
  int          fld_n = 0;
  logic [19:0] pat_x [MaxPattern];
  logic [19:0] pat_y [MaxPattern];
  int          pat_n = 0;
  bit          lists_ovf = 0;
  logic [39:0] threshold = ThrReset;

  match_res_t expected_q [$];
  int err_cnt = 0;
  int item_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt = 0;

  // Quotient rounded to 20 fraction bits, saturated to signed 32 bits.
  function automatic longint fix_quot(longint p, longint unsigned d);
    longint unsigned mag, q;
    mag = p < 0 ? longint'(-p) : p;
    q = ((mag << 20) + d / 2) / d;
    if (p < 0) return q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
    return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic void cplx_quot(longint nr, longint ni, longint dr, longint di,
                                    output longint qr, output longint qi);
    longint unsigned den;
    den = dr * dr + di * di;
    qr = fix_quot(nr * dr + ni * di, den);
    qi = fix_quot(ni * dr - nr * di, den);
  endfunction

  function automatic bit is_close(longint ar, longint ai, longint br, longint bi);
    longint er, ei;
    longint unsigned sq;
    er = ar - br;
    ei = ai - bi;
    if (er < 0) er = -er;
    if (ei < 0) ei = -ei;
    if (er > 2097152 || ei > 2097152) return 0;
    sq = er * er + ei * ei;
    return sq < {24'd0, threshold};
  endfunction

  // Search the field for the normalized pattern; first matching pair wins.
  function automatic match_res_t search_pattern();
    match_res_t r;
    longint pn_re [MaxPattern];
    longint pn_im [MaxPattern];
    longint cdr, cdi, jx, jy, fdr, fdi, nr, ni, sr, si;
    bit all_found, found;
    r = '0;
    r.status = StOk;
    if (lists_ovf) begin
      r.status = StOverflow;
      return r;
    end
    if (pat_n < 3) begin
      r.status = StFew;
      return r;
    end
    cdr = longint'(pat_x[0]) - longint'(pat_x[1]);
    cdi = longint'(pat_y[0]) - longint'(pat_y[1]);
    if (cdr == 0 && cdi == 0) begin
      r.status = StDegen;
      return r;
    end
    for (int i = 2; i < pat_n; i++) begin
      cplx_quot(longint'(pat_x[i]) - longint'(pat_x[0]),
                longint'(pat_y[i]) - longint'(pat_y[0]), cdr, cdi, pn_re[i], pn_im[i]);
    end
    for (int j = 0; j < fld_n; j++) begin
      jx = longint'(fld_x[j]);
      jy = longint'(fld_y[j]);
      for (int k = 0; k < fld_n; k++) begin
        if (k == j) continue;
        fdr = jx - longint'(fld_x[k]);
        fdi = jy - longint'(fld_y[k]);
        if (fdr == 0 && fdi == 0) continue;
        all_found = 1;
        for (int i = 2; i < pat_n && all_found; i++) begin
          found = 0;
          for (int l = 0; l < fld_n && !found; l++) begin
            if (l == j || l == k) continue;
            cplx_quot(longint'(fld_x[l]) - jx, longint'(fld_y[l]) - jy, fdr, fdi, nr, ni);
            found = is_close(nr, ni, pn_re[i], pn_im[i]);
          end
          all_found = found;
        end
        if (all_found) begin
          cplx_quot(cdr, cdi, fdr, fdi, sr, si);
          r.matched = 1'b1;
          r.scale_re = sr[31:0];
          r.scale_im = si[31:0];
          r.position_x = fld_x[j];
          r.position_y = fld_y[j];
          return r;
        end
      end
    end
    return r;
  endfunction

  // Update the predicted state for one accepted item; a run queues its result.
  function automatic void accept_item(logic [1:0] op, logic rs, logic [19:0] x,
                                      logic [19:0] y, logic typed, status_e st);
    match_res_t r;
    case (op)
      OpField: begin
        if (rs) begin
          fld_n = 0;
          lists_ovf = 0;
        end
        if (fld_n < MaxField) begin
          fld_x[fld_n] = x;
          fld_y[fld_n] = y;
          fld_n++;
        end else begin
          lists_ovf = 1;
        end
      end
      OpPattern: begin
        if (rs) begin
          pat_n = 0;
          lists_ovf = 0;
        end
        if (pat_n < MaxPattern) begin
          pat_x[pat_n] = x;
          pat_y[pat_n] = y;
          pat_n++;
        end else begin
          lists_ovf = 1;
        end
      end
      OpRun: begin
        if (typed) begin
          r = '0;
          r.status = st;
        end else begin
          r = search_pattern();
        end
        expected_q = {expected_q, r};
      end
      default: ;
    endcase
  endfunction

  // Offer one item; entered and left at a falling edge.
  task automatic send(logic [1:0] op, logic rs, logic [19:0] x, logic [19:0] y,
                      logic typed = 1'b0, status_e st = StOk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    restart_i <= rs;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    accept_item(op, rs, x, y, typed, st);
    if (op != OpNone) item_cnt++;
    @(negedge clk_i);
  endtask

  // Write the threshold once all queued results have drained.
  task automatic write_threshold(logic [39:0] v);
    in_valid_i <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
  endtask

  // One load-and-search sequence with random content.
  task automatic run_sequence();
    int kind, nf, np, idx;
    logic [19:0] ox, oy;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      nf = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 4);
      if ($urandom_range(0, 7) == 0) nf = 5;
      for (int i = 0; i < nf; i++) begin
        // Occasionally repeat a star to form a degenerate field pair.
        if (i > 0 && $urandom_range(0, 7) == 0) begin
          idx = $urandom_range(0, i - 1);
          send(OpField, i == 0, fld_x[idx], fld_y[idx]);
        end else begin
          send(OpField, i == 0, 20'($urandom), 20'($urandom));
        end
      end
      np = $urandom_range(3, 4);
      ox = $urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 255)) : 20'd0;
      oy = $urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 255)) : 20'd0;
      for (int i = 0; i < np; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, nf - 1);
          send(OpPattern, i == 0, fld_x[idx] + ox, fld_y[idx] + oy);
        end else begin
          send(OpPattern, i == 0, 20'($urandom), 20'($urandom));
        end
      end
      send(OpRun, $urandom_range(1), 20'($urandom), 20'($urandom));
    end else if (kind == 7) begin
      // Noise: mixed loads, unused op and restarts.
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(2))
          0: send(OpField, $urandom_range(1), 20'($urandom), 20'($urandom));
          1: send(OpPattern, $urandom_range(1), 20'($urandom), 20'($urandom));
          default: send(OpNone, $urandom_range(1), 20'($urandom), 20'($urandom));
        endcase
      end
      if (fld_n <= 5 && pat_n <= 6) send(OpRun, 1'b0, 20'($urandom), 20'($urandom));
    end else begin
      // Broken pattern: too short or with equal reference stars.
      ox = 20'($urandom);
      oy = 20'($urandom);
      send(OpPattern, 1'b1, ox, oy);
      if ($urandom_range(1)) begin
        send(OpPattern, 1'b0, ox, oy);
        send(OpPattern, 1'b0, 20'($urandom), 20'($urandom));
      end
      if (fld_n <= 5) send(OpRun, 1'b0, 20'($urandom), 20'($urandom));
    end
  endtask

  // Directed opening: reset state, extremes, degenerate cases, unused op.
  stim_row_t dir_tbl [0:18] = '{
    '{OpRun,     1'b0, 20'h00000, 20'h00000, 1'b1, StFew},
    '{OpPattern, 1'b1, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpPattern, 1'b0, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpPattern, 1'b0, 20'hFFFFF, 20'hFFFFF, 1'b0, StOk},
    '{OpRun,     1'b0, 20'h00000, 20'h00000, 1'b1, StDegen},
    '{OpPattern, 1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, StOk},
    '{OpPattern, 1'b0, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpRun,     1'b0, 20'hFFFFF, 20'hFFFFF, 1'b1, StFew},
    '{OpPattern, 1'b0, 20'h00000, 20'hFFFFF, 1'b0, StOk},
    '{OpRun,     1'b0, 20'h00000, 20'h00000, 1'b1, StOk},
    '{OpField,   1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, StOk},
    '{OpField,   1'b0, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpRun,     1'b0, 20'h00000, 20'h00000, 1'b1, StOk},
    '{OpField,   1'b0, 20'h00000, 20'hFFFFF, 1'b0, StOk},
    '{OpField,   1'b0, 20'hFFFFF, 20'h00000, 1'b0, StOk},
    '{OpRun,     1'b0, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpField,   1'b0, 20'h00000, 20'h00000, 1'b0, StOk},
    '{OpNone,    1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, StOk},
    '{OpRun,     1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, StOk}
  };

  // Receiver side: random stalls and one long hold-off on request.
  initial begin
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    match_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: matched %0d status %0d", matched_o, status_o);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (matched_o !== e.matched) begin
          $error("matched: expected %0d, got %0d", e.matched, matched_o);
          err_cnt++;
        end
        if (scale_re_o !== e.scale_re) begin
          $error("scale_re: expected %0d, got %0d", e.scale_re, scale_re_o);
          err_cnt++;
        end
        if (scale_im_o !== e.scale_im) begin
          $error("scale_im: expected %0d, got %0d", e.scale_im, scale_im_o);
          err_cnt++;
        end
        if (position_x_o !== e.position_x) begin
          $error("position_x: expected %0h, got %0h", e.position_x, position_x_o);
          err_cnt++;
        end
        if (position_y_o !== e.position_y) begin
          $error("position_y: expected %0h, got %0h", e.position_y, position_y_o);
          err_cnt++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("FAIL star_pattern_matcher");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      send(dir_tbl[i].op, dir_tbl[i].restart, dir_tbl[i].x, dir_tbl[i].y,
           dir_tbl[i].typed, dir_tbl[i].exp_status);
    end

    // Full field list: the extra load is dropped and the run reports overflow.
    for (int i = 0; i <= MaxField; i++) send(OpField, i == 0, 20'($urandom), 20'($urandom));
    send(OpRun, 1'b0, 20'd0, 20'd0, 1'b1, StOverflow);
    send(OpField, 1'b1, 20'h12345, 20'h54321);
    send(OpField, 1'b0, 20'h00100, 20'h00200);
    send(OpField, 1'b0, 20'h00300, 20'h00050);
    // Full pattern list the same way.
    for (int i = 0; i <= MaxPattern; i++) send(OpPattern, i == 0, 20'($urandom),
                                                20'($urandom));
    send(OpRun, 1'b0, 20'd0, 20'd0, 1'b1, StOverflow);
    send(OpPattern, 1'b1, 20'h00300, 20'h00050);
    send(OpPattern, 1'b0, 20'h12345, 20'h54321);
    send(OpPattern, 1'b0, 20'h00100, 20'h00200);
    send(OpRun, 1'b0, 20'd0, 20'd0);

    // Random phases, each with its own threshold and idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          write_threshold(40'd0);
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          write_threshold(40'hFF_FFFF_FFFF);
          send_idle_pct = 0;
          recv_stall_pct = 61;
          hold_req_cnt++;
        end
        3: begin
          write_threshold(40'($urandom_range(0, 1 << 30)) << $urandom_range(0, 9));
          send_idle_pct = 7;
          recv_stall_pct = 7;
        end
        default: ;
      endcase
      while (item_cnt < (ph + 1) * PhaseItems) run_sequence();
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS star_pattern_matcher");
    end else begin
      $display("FAIL star_pattern_matcher");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/spm_pkg.sv
rtl/spm_cdiv.sv
rtl/spm_dpath.sv
rtl/spm_ctrl.sv
rtl/star_pattern_matcher.sv
bench/star_pattern_matcher_tb.sv
